// ===== rtl/prc_pkg.sv =====
// Shared types and constants for the polar/rectangular CORDIC converter.
// Holds the per-stage payload struct, the gain constant and the arctangent table.
package prc_pkg;

    localparam int DATA_W    = 36;     // x/y datapath, 16 fraction bits
    localparam int ANGLE_W   = 34;     // angle accumulator, 2^31 = pi
    localparam int FRAC_BITS = 16;
    localparam int MAX_STAGES = 24;

    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;

    typedef enum logic
    {
        ACT_TO_POLAR = 1'b0,
        ACT_TO_RECT  = 1'b1
    } action_t;

    // Payload that runs through the CORDIC iterations
    typedef struct packed
    {
        logic                       vec_mode;
        logic                       origin;
        logic signed [DATA_W-1:0]   x;
        logic signed [DATA_W-1:0]   y;
        logic signed [ANGLE_W-1:0]  z;
    } cordic_t;

    // atan(2^-i) as 32-bit binary angle
    function automatic logic [31:0] atan_angle(input int idx);
        logic [31:0] a;
        begin
            case (idx)
                0:       a = 32'd536870912;
                1:       a = 32'd316933406;
                2:       a = 32'd167458907;
                3:       a = 32'd85004756;
                4:       a = 32'd42667331;
                5:       a = 32'd21354465;
                6:       a = 32'd10679838;
                7:       a = 32'd5340245;
                8:       a = 32'd2670163;
                9:       a = 32'd1335087;
                10:      a = 32'd667544;
                11:      a = 32'd333772;
                12:      a = 32'd166886;
                13:      a = 32'd83443;
                14:      a = 32'd41722;
                15:      a = 32'd20861;
                16:      a = 32'd10430;
                17:      a = 32'd5215;
                18:      a = 32'd2608;
                19:      a = 32'd1304;
                20:      a = 32'd652;
                21:      a = 32'd326;
                22:      a = 32'd163;
                23:      a = 32'd81;
                default: a = 32'd0;
            endcase
            return a;
        end
    endfunction

endpackage

// ===== rtl/prc_pre.sv =====
// Front end: gain-scaling multiply, then quadrant fold and CORDIC start vector.
// Two register stages with per-stage valid/ready; uses prc_pkg.
module prc_pre
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic signed [15:0]          coord_x,
    input  logic signed [15:0]          coord_y,
    input  logic [15:0]                 radius_in,
    input  logic signed [15:0]          angle_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output prc_pkg::cordic_t            out_data
);

    // stage A
    logic                   a_valid_reg;
    logic                   a_ready;
    logic                   a_action_reg;
    logic signed [15:0]     a_cx_reg;
    logic signed [15:0]     a_cy_reg;
    logic signed [15:0]     a_ang_reg;
    logic [45:0]            a_prod_reg;
    logic [45:0]            a_prod_next;

    // stage B
    logic                   b_valid_reg;
    logic                   b_ready;
    prc_pkg::cordic_t       b_data_reg;
    prc_pkg::cordic_t       b_data_next;

    logic signed [prc_pkg::DATA_W-1:0]  vx;
    logic signed [prc_pkg::DATA_W-1:0]  vy;
    logic signed [prc_pkg::DATA_W-1:0]  rx;
    logic signed [prc_pkg::ANGLE_W-1:0] rz;

    assign a_prod_next = 46'(radius_in) * 46'(prc_pkg::GAIN_Q30);

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_action_reg <= action;
            a_cx_reg     <= coord_x;
            a_cy_reg     <= coord_y;
            a_ang_reg    <= angle_in;
            a_prod_reg   <= a_prod_next;
        end
    end

    always_comb
    begin
        vx = {{(prc_pkg::DATA_W-32){a_cx_reg[15]}}, a_cx_reg, 16'd0};
        vy = {{(prc_pkg::DATA_W-32){a_cy_reg[15]}}, a_cy_reg, 16'd0};
        rx = prc_pkg::DATA_W'(a_prod_reg[45:14]);
        rz = {{(prc_pkg::ANGLE_W-32){a_ang_reg[15]}}, a_ang_reg, 16'd0};

        b_data_next.vec_mode = (prc_pkg::action_t'(a_action_reg) == prc_pkg::ACT_TO_POLAR);
        b_data_next.origin   = (a_cx_reg == 16'sd0) && (a_cy_reg == 16'sd0);

        if (prc_pkg::action_t'(a_action_reg) == prc_pkg::ACT_TO_POLAR)
        begin
            // left half plane: turn by pi first
            if (a_cx_reg < 16'sd0)
            begin
                b_data_next.x = -vx;
                b_data_next.y = -vy;
                b_data_next.z = prc_pkg::HALF_TURN;
            end
            else
            begin
                b_data_next.x = vx;
                b_data_next.y = vy;
                b_data_next.z = '0;
            end
        end
        else
        begin
            b_data_next.y = '0;
            if (rz > prc_pkg::QUARTER_TURN)
            begin
                b_data_next.x = -rx;
                b_data_next.z = rz - prc_pkg::HALF_TURN;
            end
            else if (rz < -prc_pkg::QUARTER_TURN)
            begin
                b_data_next.x = -rx;
                b_data_next.z = rz + prc_pkg::HALF_TURN;
            end
            else
            begin
                b_data_next.x = rx;
                b_data_next.z = rz;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

endmodule

// ===== rtl/prc_stage.sv =====
// One CORDIC micro-rotation by atan(2^-SHIFT), registered, with valid/ready.
// Vectoring drives y toward zero, rotation drives z toward zero; uses prc_pkg.
module prc_stage
#(
    parameter int SHIFT = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  prc_pkg::cordic_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output prc_pkg::cordic_t    out_data
);

    localparam logic signed [prc_pkg::ANGLE_W-1:0] STEP_ANGLE =
        prc_pkg::ANGLE_W'(prc_pkg::atan_angle(SHIFT));

    logic                       valid_reg;
    prc_pkg::cordic_t           data_reg;
    prc_pkg::cordic_t           data_next;
    logic signed [prc_pkg::DATA_W-1:0] xs;
    logic signed [prc_pkg::DATA_W-1:0] ys;
    logic                       ccw;

    always_comb
    begin
        xs  = in_data.x >>> SHIFT;
        ys  = in_data.y >>> SHIFT;
        ccw = in_data.vec_mode ? in_data.y[prc_pkg::DATA_W-1] : !in_data.z[prc_pkg::ANGLE_W-1];

        data_next          = in_data;
        if (ccw)
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - STEP_ANGLE;
        end
        else
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + STEP_ANGLE;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/prc_post.sv =====
// Back end: gain multiply of the vector length and rounding of the rotated
// point, then final rounding, saturation and output register; uses prc_pkg.
module prc_post
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  prc_pkg::cordic_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         radius_out,
    output logic signed [15:0]  angle_out,
    output logic signed [16:0]  x_out,
    output logic signed [16:0]  y_out
);

    localparam logic signed [20:0] SAT_HI = 21'sd65535;
    localparam logic signed [20:0] SAT_LO = -21'sd65535;

    // stage C
    logic                   c_valid_reg;
    logic                   c_ready;
    logic                   c_vec_reg;
    logic                   c_origin_reg;
    logic [62:0]            c_prod_reg;
    logic [62:0]            c_prod_next;
    logic signed [15:0]     c_ang_reg;
    logic signed [15:0]     c_ang_next;
    logic signed [16:0]     c_rx_reg;
    logic signed [16:0]     c_rx_next;
    logic signed [16:0]     c_ry_reg;
    logic signed [16:0]     c_ry_next;

    // stage D (output register)
    logic                   d_valid_reg;
    logic                   d_ready;
    logic [15:0]            d_rad_reg;
    logic [15:0]            d_rad_next;
    logic signed [15:0]     d_ang_reg;
    logic signed [16:0]     d_x_reg;
    logic signed [16:0]     d_y_reg;

    logic [32:0]                        xmag;
    logic [31:0]                        zr;
    logic signed [prc_pkg::DATA_W:0]    xr;
    logic signed [prc_pkg::DATA_W:0]    yr;
    logic signed [20:0]                 xq;
    logic signed [20:0]                 yq;
    logic [62:0]                        rsum;

    always_comb
    begin
        // negative length cannot occur for a real vector, clamp anyway
        xmag        = in_data.x[prc_pkg::DATA_W-1] ? 33'd0 : in_data.x[32:0];
        c_prod_next = 63'(xmag) * 63'(prc_pkg::GAIN_Q30);

        zr          = in_data.z[31:0] + 32'd32768;
        c_ang_next  = zr[31:16];

        xr = (prc_pkg::DATA_W+1)'(in_data.x) + (prc_pkg::DATA_W+1)'(32768);
        yr = (prc_pkg::DATA_W+1)'(in_data.y) + (prc_pkg::DATA_W+1)'(32768);
        xq = 21'(xr >>> prc_pkg::FRAC_BITS);
        yq = 21'(yr >>> prc_pkg::FRAC_BITS);
        c_rx_next = (xq > SAT_HI) ? 17'(SAT_HI) : ((xq < SAT_LO) ? 17'(SAT_LO) : 17'(xq));
        c_ry_next = (yq > SAT_HI) ? 17'(SAT_HI) : ((yq < SAT_LO) ? 17'(SAT_LO) : 17'(yq));
    end

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign in_ready = c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_vec_reg    <= in_data.vec_mode;
            c_origin_reg <= in_data.origin;
            c_prod_reg   <= c_prod_next;
            c_ang_reg    <= c_ang_next;
            c_rx_reg     <= c_rx_next;
            c_ry_reg     <= c_ry_next;
        end
    end

    always_comb
    begin
        rsum       = c_prod_reg + 63'(64'd1 << 45);
        d_rad_next = (rsum[62:46] > 17'd65535) ? 16'hFFFF : rsum[61:46];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && c_valid_reg)
        begin
            if (c_vec_reg)
            begin
                d_rad_reg <= c_origin_reg ? 16'd0 : d_rad_next;
                d_ang_reg <= c_origin_reg ? 16'sd0 : c_ang_reg;
                d_x_reg   <= '0;
                d_y_reg   <= '0;
            end
            else
            begin
                d_rad_reg <= '0;
                d_ang_reg <= '0;
                d_x_reg   <= c_rx_reg;
                d_y_reg   <= c_ry_reg;
            end
        end
    end

    assign out_valid  = d_valid_reg;
    assign radius_out = d_rad_reg;
    assign angle_out  = d_ang_reg;
    assign x_out      = d_x_reg;
    assign y_out      = d_y_reg;

endmodule

// ===== rtl/polar_rect_converter.sv =====
// Polar/rectangular converter, unrolled gain-compensated CORDIC pipeline.
// Register stages: two front-end stages, one per CORDIC iteration (capped at
// MAX_STAGES), two back-end stages. Throughput: one item per cycle while out_stall is low.
// Every stage has its own valid bit and takes data when it is empty or moving.
// Reset (rst_n low, asynchronous) clears all valid bits; no other state.
module polar_rect_converter
#(
    parameter int CORDIC_STAGES = 18
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic signed [15:0]  coord_x,
    input  logic signed [15:0]  coord_y,
    input  logic [15:0]         radius_in,
    input  logic signed [15:0]  angle_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         radius_out,
    output logic signed [15:0]  angle_out,
    output logic signed [16:0]  x_out,
    output logic signed [16:0]  y_out
);

    localparam int N_STAGES = (CORDIC_STAGES > prc_pkg::MAX_STAGES) ?
                              prc_pkg::MAX_STAGES : CORDIC_STAGES;

    logic               pre_ready;
    logic               st_valid [N_STAGES+1];
    logic               st_ready [N_STAGES+1];
    prc_pkg::cordic_t   st_data  [N_STAGES+1];

    prc_pre u_pre
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (pre_ready),
        .action    (action),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .radius_in (radius_in),
        .angle_in  (angle_in),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_data  (st_data[0])
    );

    assign in_stall = !pre_ready;

    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_stage
        prc_stage
        #(
            .SHIFT (i)
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_data   (st_data[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_data  (st_data[i+1])
        );
    end

    prc_post u_post
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (st_valid[N_STAGES]),
        .in_ready   (st_ready[N_STAGES]),
        .in_data    (st_data[N_STAGES]),
        .out_valid  (out_valid),
        .out_ready  (!out_stall),
        .radius_out (radius_out),
        .angle_out  (angle_out),
        .x_out      (x_out),
        .y_out      (y_out)
    );

endmodule
